>>> sv/u8cc_pkg.sv
// ----------------------------------------------------------------------------
// u8cc_pkg
// Shared types and constants for the UTF-8 character classifier.
// ----------------------------------------------------------------------------
package u8cc_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CLASS_W = 4;
    localparam int unsigned CODE_W  = 21;
    localparam int unsigned PEND_W  = 2;

    // code point limits
    localparam logic [CODE_W-1:0] CODE_LIMIT = 21'h110000;
    localparam logic [CODE_W-1:0] BMP_LIMIT  = 21'h010000;
    localparam logic [CODE_W-1:0] ASCII_END  = 21'h000080;

    // payload masks of lead and continuation bytes
    localparam logic [BYTE_W-1:0] CONT_MASK  = 8'h3F;
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'h1F;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'h0F;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'h07;

    // number of continuation bytes still expected
    localparam logic [PEND_W-1:0] PEND_NONE  = 2'd0;
    localparam logic [PEND_W-1:0] PEND_ONE   = 2'd1;
    localparam logic [PEND_W-1:0] PEND_TWO   = 2'd2;
    localparam logic [PEND_W-1:0] PEND_THREE = 2'd3;

    typedef enum logic [CLASS_W-1:0] {
        CLASS_ALNUM      = 4'd0,
        CLASS_ASCII      = 4'd1,
        CLASS_INVALID    = 4'd2,
        CLASS_KANA       = 4'd3,
        CLASS_HANGUL     = 4'd4,
        CLASS_KANJI      = 4'd5,
        CLASS_PRIVATE    = 4'd6,
        CLASS_IGNORABLE  = 4'd7,
        CLASS_OTHER      = 4'd8
    } char_class_t;

    // one decoded result word
    typedef struct packed {
        logic              char_done;
        logic [CLASS_W-1:0] char_class;
        logic [CODE_W-1:0]  code_point;
        logic              malformed;
    } result_t;

endpackage

>>> sv/u8cc_byte_if.sv
// ----------------------------------------------------------------------------
// u8cc_byte_if
// Valid/ready channel carrying one raw byte of the UTF-8 stream.
// ----------------------------------------------------------------------------
interface u8cc_byte_if;
    logic                         valid;
    logic                         ready;
    logic [u8cc_pkg::BYTE_W-1:0]  byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

>>> sv/u8cc_char_if.sv
// ----------------------------------------------------------------------------
// u8cc_char_if
// Valid/ready channel carrying one decoder result word.
// ----------------------------------------------------------------------------
interface u8cc_char_if;
    logic                          valid;
    logic                          ready;
    logic                          char_done;
    logic [u8cc_pkg::CLASS_W-1:0]  char_class;
    logic [u8cc_pkg::CODE_W-1:0]   code_point;
    logic                          malformed;

    modport source (output valid, output char_done, output char_class,
                    output code_point, output malformed, input ready);
    modport sink   (input valid, input char_done, input char_class,
                    input code_point, input malformed, output ready);
endinterface

>>> sv/u8cc_classify.sv
// ----------------------------------------------------------------------------
// u8cc_classify
// Maps a decoded code point onto its character class.
// ----------------------------------------------------------------------------
module u8cc_classify
(
    input  logic [u8cc_pkg::CODE_W-1:0] code_point,
    output u8cc_pkg::char_class_t       char_class
);

    logic [u8cc_pkg::BYTE_W-1:0] low_byte;
    logic [15:0]                 bmp;
    logic                        is_alnum_ascii;
    logic                        is_print_ascii;

    assign low_byte = code_point[u8cc_pkg::BYTE_W-1:0];
    assign bmp      = code_point[15:0];

    // ASCII digits and letters, then printable and white space
    assign is_alnum_ascii = (low_byte >= 8'h30 && low_byte <= 8'h39) ||
                            (low_byte >= 8'h41 && low_byte <= 8'h5A) ||
                            (low_byte >= 8'h61 && low_byte <= 8'h7A);
    assign is_print_ascii = (low_byte == 8'h09) || (low_byte == 8'h0A) ||
                            (low_byte == 8'h0D) ||
                            (low_byte >= 8'h20 && low_byte <= 8'h7E);

    // pick the first matching range
    always_comb
    begin
        priority if (code_point < u8cc_pkg::ASCII_END)
        begin
            if (is_alnum_ascii)
                char_class = u8cc_pkg::CLASS_ALNUM;
            else if (is_print_ascii)
                char_class = u8cc_pkg::CLASS_ASCII;
            else
                char_class = u8cc_pkg::CLASS_INVALID;
        end
        else if (code_point >= u8cc_pkg::BMP_LIMIT)
            char_class = u8cc_pkg::CLASS_OTHER;
        else if (bmp >= 16'h3040 && bmp <= 16'h30FF)
            char_class = u8cc_pkg::CLASS_KANA;
        else if ((bmp >= 16'h1100 && bmp <= 16'h11FF) ||
                 (bmp >= 16'hAC00 && bmp <= 16'hD7AF))
            char_class = u8cc_pkg::CLASS_HANGUL;
        else if (bmp >= 16'h4E00 && bmp <= 16'h9FFF)
            char_class = u8cc_pkg::CLASS_KANJI;
        else if (bmp >= 16'hE000 && bmp <= 16'hF8FF)
            char_class = u8cc_pkg::CLASS_PRIVATE;
        else if (bmp == 16'hFEFF)
            char_class = u8cc_pkg::CLASS_IGNORABLE;
        else if ((bmp >= 16'hFF10 && bmp <= 16'hFF19) ||
                 (bmp >= 16'hFF21 && bmp <= 16'hFF3A) ||
                 (bmp >= 16'hFF41 && bmp <= 16'hFF5A))
            char_class = u8cc_pkg::CLASS_ALNUM;
        else if (bmp >= 16'hFF66 && bmp <= 16'hFF9D)
            char_class = u8cc_pkg::CLASS_KANA;
        else if (bmp >= 16'hFFA1 && bmp <= 16'hFFDC)
            char_class = u8cc_pkg::CLASS_HANGUL;
        else
            char_class = u8cc_pkg::CLASS_OTHER;
    end

endmodule

>>> sv/utf8_char_classifier_unit.sv
// ----------------------------------------------------------------------------
// utf8_char_classifier_unit
// Decodes a UTF-8 byte stream and reports each completed code point with
// its character class and a sticky malformed flag.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                         words
//  byte_ch   in   byte_in[7:0]                                    1 per byte
//  char_ch   out  char_done, char_class[3:0], code_point[20:0],   1 per byte
//                 malformed
//
//  One byte is taken per cycle while byte_ch is ready; its word is registered.
//  Decode and class lookup sit between the decoder state and the output
//  register, so throughput is set by that single pass.
//  Reset clears the decoder state, the error flag and both slots' valid bits.
//  A two-slot output stage (register plus skid) keeps byte_ch ready for one
//  more word while char_ch is stalled; byte_ch drops ready once both fill.
// ----------------------------------------------------------------------------
module utf8_char_classifier_unit
(
    input  logic           clk,
    input  logic           rst_n,
    u8cc_byte_if.sink      byte_ch,
    u8cc_char_if.source    char_ch
);

    logic [u8cc_pkg::PEND_W-1:0] pend_reg,    pend_next;
    logic [u8cc_pkg::CODE_W-1:0] partial_reg, partial_next;
    logic                        error_reg,   error_next;

    u8cc_pkg::result_t out_data_reg,  out_data_next;
    logic              out_valid_reg, out_valid_next;
    u8cc_pkg::result_t skid_data_reg, skid_data_next;
    logic              skid_valid_reg, skid_valid_next;

    logic                          in_fire;
    logic                          out_fire;
    logic [u8cc_pkg::BYTE_W-1:0]   b;
    logic                          is_cont;
    logic [u8cc_pkg::CODE_W-1:0]   shifted;
    logic                          done;
    logic [u8cc_pkg::CODE_W-1:0]   cp;
    u8cc_pkg::char_class_t         cls;
    u8cc_pkg::result_t             res;

    assign byte_ch.ready = !skid_valid_reg;
    assign in_fire       = byte_ch.valid && byte_ch.ready;
    assign out_fire      = char_ch.valid && char_ch.ready;

    assign b       = byte_ch.byte_in;
    assign is_cont = (b[7:6] == 2'b10);
    assign shifted = {partial_reg[u8cc_pkg::CODE_W-7:0], b[5:0]};

    // decode one byte against the pending state
    always_comb
    begin
        pend_next    = pend_reg;
        partial_next = partial_reg;
        error_next   = error_reg;
        done         = 1'b0;
        cp           = '0;
        if (in_fire && !error_reg)
        begin
            if (pend_reg == u8cc_pkg::PEND_NONE)
            begin
                priority if (!b[7])
                begin
                    done = 1'b1;
                    cp   = u8cc_pkg::CODE_W'(b);
                end
                else if (is_cont)
                    error_next = 1'b1;
                else if (b < 8'hE0)
                begin
                    pend_next    = u8cc_pkg::PEND_ONE;
                    partial_next = u8cc_pkg::CODE_W'(b & u8cc_pkg::LEAD2_MASK);
                end
                else if (b < 8'hF0)
                begin
                    pend_next    = u8cc_pkg::PEND_TWO;
                    partial_next = u8cc_pkg::CODE_W'(b & u8cc_pkg::LEAD3_MASK);
                end
                else if (b < 8'hF8)
                begin
                    pend_next    = u8cc_pkg::PEND_THREE;
                    partial_next = u8cc_pkg::CODE_W'(b & u8cc_pkg::LEAD4_MASK);
                end
                else
                    error_next = 1'b1;
            end
            else if (!is_cont)
            begin
                error_next   = 1'b1;
                pend_next    = u8cc_pkg::PEND_NONE;
                partial_next = '0;
            end
            else
            begin
                pend_next = pend_reg - 1'b1;
                if (pend_reg == u8cc_pkg::PEND_ONE)
                begin
                    partial_next = '0;
                    if (shifted >= u8cc_pkg::CODE_LIMIT)
                        error_next = 1'b1;
                    else
                    begin
                        done = 1'b1;
                        cp   = shifted;
                    end
                end
                else
                    partial_next = shifted;
            end
        end
    end

    u8cc_classify u_classify
    (
        .code_point (cp),
        .char_class (cls)
    );

    // assemble the result word
    always_comb
    begin
        res.char_done  = done;
        res.char_class = done ? cls : u8cc_pkg::CLASS_ALNUM;
        res.code_point = cp;
        res.malformed  = error_next;
    end

    // steer words into the output register or the skid slot
    always_comb
    begin
        out_data_next   = out_data_reg;
        out_valid_next  = out_valid_reg;
        skid_data_next  = skid_data_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || out_fire)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_data_next  = res;
                out_valid_next = in_fire;
            end
        end
        else if (in_fire)
        begin
            skid_data_next  = res;
            skid_valid_next = 1'b1;
        end
    end

    // hold decoder state and output slots
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg       <= u8cc_pkg::PEND_NONE;
            partial_reg    <= '0;
            error_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg       <= pend_next;
            partial_reg    <= partial_next;
            error_reg      <= error_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign char_ch.valid      = out_valid_reg;
    assign char_ch.char_done  = out_data_reg.char_done;
    assign char_ch.char_class = out_data_reg.char_class;
    assign char_ch.code_point = out_data_reg.code_point;
    assign char_ch.malformed  = out_data_reg.malformed;

    // skid slot only fills behind a held output word
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid slot full with output register empty");

    // error flag never clears once set
    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        error_reg |=> error_reg)
        else $error("malformed flag cleared");

    // no sequence is in flight after an error
    a_no_pend_after_error: assert property (@(posedge clk) disable iff (!rst_n)
        error_reg |-> (pend_reg == u8cc_pkg::PEND_NONE))
        else $error("bytes pending while in error");

    // a completed character never carries the malformed flag
    a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (char_ch.valid && char_ch.char_done) |-> !char_ch.malformed)
        else $error("completed character reported as malformed");

    // an incomplete word carries zero code point and class
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (char_ch.valid && !char_ch.char_done) |->
        (char_ch.code_point == '0 && char_ch.char_class == '0))
        else $error("non-zero payload without a completed character");

endmodule
